// ===== rtl/u8ac_pkg.sv =====
// Shared types, constants and the code point range check for the UTF-8 allowed-character checker.
package u8ac_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CodeWidth    = 21;
   localparam int unsigned PendingWidth = 2;

   localparam logic [CodeWidth-1:0] CjkLow       = 21'h004E00;
   localparam logic [CodeWidth-1:0] CjkHigh      = 21'h009FFF;
   localparam logic [CodeWidth-1:0] KanaLow      = 21'h003040;
   localparam logic [CodeWidth-1:0] KanaHigh     = 21'h0030FF;
   localparam logic [CodeWidth-1:0] HangulLow    = 21'h00AC00;
   localparam logic [CodeWidth-1:0] HangulHigh   = 21'h00D7AF;
   localparam logic [CodeWidth-1:0] AsciiLow     = 21'h000020;
   localparam logic [CodeWidth-1:0] AsciiHigh    = 21'h00007E;
   localparam logic [CodeWidth-1:0] Latin1Low    = 21'h0000A0;
   localparam logic [CodeWidth-1:0] Latin1High   = 21'h0000FF;
   localparam logic [CodeWidth-1:0] LatinExtLow  = 21'h000100;
   localparam logic [CodeWidth-1:0] LatinExtHigh = 21'h00017F;

   typedef struct packed {
      logic [PendingWidth-1:0] pending;
      logic [CodeWidth-1:0]    accum;
      logic                    failed;
   } u8ac_state_type;

   function automatic logic code_in_ranges(input logic [CodeWidth-1:0] cp);
      code_in_ranges = (cp >= CjkLow      && cp <= CjkHigh)     ||
                       (cp >= KanaLow     && cp <= KanaHigh)    ||
                       (cp >= HangulLow   && cp <= HangulHigh)  ||
                       (cp >= AsciiLow    && cp <= AsciiHigh)   ||
                       (cp >= Latin1Low   && cp <= Latin1High)  ||
                       (cp >= LatinExtLow && cp <= LatinExtHigh);
   endfunction

endpackage

// ===== rtl/u8ac_step.sv =====
// Per-byte UTF-8 decode step: next decoder state and the end-of-string verdict.
module u8ac_step (
   input  u8ac_pkg::u8ac_state_type       cur_state,
   input  logic [u8ac_pkg::ByteWidth-1:0] data_byte,
   input  logic                           last_byte,
   output u8ac_pkg::u8ac_state_type       nxt_state,
   output logic                           all_allowed
);
   import u8ac_pkg::*;

   logic [CodeWidth-1:0] shifted_code;
   logic [CodeWidth-1:0] ascii_code;
   u8ac_state_type       decoded;

   assign shifted_code = {cur_state.accum[CodeWidth-7:0], data_byte[5:0]};
   assign ascii_code   = {{(CodeWidth-ByteWidth){1'b0}}, data_byte};

   always_comb begin
      decoded = cur_state;
      priority if (cur_state.pending != '0) begin
         decoded.accum   = shifted_code;
         decoded.pending = cur_state.pending - 2'd1;
         if (cur_state.pending == 2'd1 && !code_in_ranges(shifted_code)) begin
            decoded.failed = 1'b1;
         end
      end else if (data_byte[7] == 1'b0) begin
         decoded.accum = ascii_code;
         if (!code_in_ranges(ascii_code)) begin
            decoded.failed = 1'b1;
         end
      end else if (data_byte[7:5] == 3'b110) begin
         decoded.accum   = {{(CodeWidth-5){1'b0}}, data_byte[4:0]};
         decoded.pending = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
         decoded.accum   = {{(CodeWidth-4){1'b0}}, data_byte[3:0]};
         decoded.pending = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
         decoded.accum   = {{(CodeWidth-3){1'b0}}, data_byte[2:0]};
         decoded.pending = 2'd3;
      end else begin
         decoded.failed = 1'b1;
      end
   end

   // A sequence still open at the last byte counts as a failure.
   assign all_allowed = !decoded.failed && (decoded.pending == '0);
   assign nxt_state   = last_byte ? '0 : decoded;

endmodule

// ===== rtl/utf8_allowed_char_checker.sv =====
// Top level of the UTF-8 allowed-character checker with stream request and result channels.
module utf8_allowed_char_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] all_allowed, [7:1] zero
);
   // Takes one byte of a UTF-8 string per cycle and, on the byte marked
   // tlast, returns one result: 1 when every decoded code point lies in the
   // CJK, kana, Hangul, printable ASCII, Latin-1 supplement or Latin
   // Extended-A ranges, no lead byte was invalid and no sequence was cut
   // short. Bytes without tlast give no result. A request is taken into an
   // input register and decoded against the state register, and the result
   // of a string is registered in the result register when its last byte
   // is decoded. One byte per cycle is sustained while no result is stalled;
   // back-pressure on the result channel stalls the input only when a result
   // is waiting.
   import u8ac_pkg::*;

   logic                 s1_valid_ff;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 s1_last_ff;
   u8ac_state_type       state_ff;
   u8ac_state_type       state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_allowed_ff;
   logic                 rsp_allowed_in;
   logic                 advance;

   u8ac_step u_step (
      .cur_state   (state_ff),
      .data_byte   (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .nxt_state   (state_in),
      .all_allowed (rsp_allowed_in)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_allowed_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (advance && s1_last_ff) begin
         rsp_allowed_ff <= rsp_allowed_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (state_ff == '0))
      else $error("Decoder state not cleared after the last byte.");

   a_fail_latched : assert property (@(posedge clock) disable iff (reset)
      (state_ff.failed && !(advance && s1_last_ff)) |=> state_ff.failed)
      else $error("Failure flag dropped before the end of the string.");

   a_no_result_mid_string : assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_last_ff) |=> !rsp_valid_ff)
      else $error("Result presented for a byte that is not the last.");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("Input advanced while a result was stalled.");
`endif

endmodule
